// ----- hdl/sgp_pkg.sv -----
`timescale 1ns / 1ps
package sgp_pkg;

	typedef enum logic [2:0] {
		OP_LATCH = 3'd0,
		OP_READ  = 3'd1,
		OP_PAD   = 3'd2,
		OP_MOUSE = 3'd3,
		OP_GUN   = 3'd4
	} opcode_t;

	localparam logic [1:0] KIND_PAD   = 2'd0;
	localparam logic [1:0] KIND_MOUSE = 2'd1;
	localparam logic [1:0] KIND_GUN   = 2'd2;

	localparam logic REG_DEVICE_KIND = 1'b0;
	localparam logic REG_MOUSE_SPEED = 1'b1;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic signed [15:0] CLAMP_MAX   = 16'sd127;
	localparam logic [15:0]        PAD_FILL    = 16'h8000;
	localparam logic [3:0]         GUN_NOISE   = 4'hF;
	localparam logic [15:0]        GUN_Y_LIMIT = 16'd224;
	localparam logic [5:0]         MOUSE_BITS  = 6'd32;

	// sign and magnitude of an accumulator, clamped to +/-127
	function automatic logic [7:0] axis_bits(input logic [15:0] acc);
		logic signed [15:0] v;
		logic signed [15:0] neg;
		logic [7:0]         r;
		v   = $signed(acc);
		neg = -v;
		if (v > CLAMP_MAX) begin
			r = {1'b0, 7'h7F};
		end else if (v < -CLAMP_MAX) begin
			r = {1'b1, 7'h7F};
		end else if (v < 16'sd0) begin
			r = {1'b1, neg[6:0]};
		end else begin
			r = {1'b0, v[6:0]};
		end
		return r;
	endfunction

	function automatic logic [31:0] build_mouse(
		input logic [1:0]  speed,
		input logic [1:0]  buttons,
		input logic [15:0] acc_x,
		input logic [15:0] acc_y
	);
		return {2'b00, speed, 3'b000, 1'b1, buttons[1], buttons[0], 6'b0,
			axis_bits(acc_y), axis_bits(acc_x)};
	endfunction

	function automatic logic [15:0] build_gun(
		input logic [3:0] buttons,
		input logic       offscreen
	);
		return {7'b0, offscreen, buttons, offscreen ? 4'h0 : GUN_NOISE};
	endfunction

endpackage

// ----- hdl/serial_game_port_shifter.sv -----
`timescale 1ns / 1ps
// Game port serial shifter for a standard pad, a mouse or a light gun. It takes
// one item (latch write, data bit read or host device update) in every clock
// cycle. An item is registered at its input transfer and applied to the device
// state when it leaves the input register; a data bit read puts its bit into
// the output register at that same edge. The input side stalls only while a
// read waits in the input register and the output register holds an untaken
// bit under stall. The APB port always answers with pready high; device_kind
// is at address 0, mouse_speed at 4.
module serial_game_port_shifter (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [sgp_pkg::PADDR_W-1:0]    paddr,
	input  logic [sgp_pkg::PDATA_W-1:0]    pwdata,
	output logic [sgp_pkg::PDATA_W-1:0]    prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [2:0]                     opcode,
	input  logic                           latch_level,
	input  logic [15:0]                    pad_buttons,
	input  logic signed [15:0]             move_dx,
	input  logic signed [15:0]             move_dy,
	input  logic [3:0]                     button_bits,
	input  logic [15:0]                    aim_x,
	input  logic [15:0]                    aim_y,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           data_bit
);
	import sgp_pkg::*;

	logic [1:0] device_kind_q;
	logic [1:0] mouse_speed_q;

	logic        valid_s1;
	logic [2:0]  opcode_s1;
	logic        latch_level_s1;
	logic [15:0] pad_buttons_s1;
	logic [15:0] move_dx_s1;
	logic [15:0] move_dy_s1;
	logic [3:0]  button_bits_s1;
	logic [15:0] aim_x_s1;
	logic [15:0] aim_y_s1;

	logic        latch_held_q;
	logic [15:0] pad_word_q;
	logic [15:0] shift_word_q;
	logic [15:0] accum_x_q;
	logic [15:0] accum_y_q;
	logic [1:0]  mouse_buttons_q;
	logic [31:0] mouse_packet_q;
	logic [5:0]  mouse_count_q;
	logic [3:0]  gun_buttons_q;
	logic        gun_offscreen_q;

	logic        out_valid_q;
	logic        data_bit_q;

	logic        latch_held_d;
	logic [15:0] pad_word_d;
	logic [15:0] shift_word_d;
	logic [15:0] accum_x_d;
	logic [15:0] accum_y_d;
	logic [1:0]  mouse_buttons_d;
	logic [31:0] mouse_packet_d;
	logic [5:0]  mouse_count_d;
	logic [3:0]  gun_buttons_d;
	logic        gun_offscreen_d;
	logic        bit_d;

	logic        is_read_s1;
	logic        advance_s1;
	logic        in_xfer;
	logic        is_mouse;
	logic [31:0] mouse_build;
	logic [15:0] capture;
	logic [15:0] pad_shift;

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_kind_q <= KIND_PAD;
			mouse_speed_q <= 2'd0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_DEVICE_KIND: device_kind_q <= pwdata[1:0];
				REG_MOUSE_SPEED: mouse_speed_q <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_DEVICE_KIND: prdata = {{(PDATA_W-2){1'b0}}, device_kind_q};
			REG_MOUSE_SPEED: prdata = {{(PDATA_W-2){1'b0}}, mouse_speed_q};
			default:         prdata = '0;
		endcase
	end

	// input register
	assign is_read_s1 = (opcode_s1 == OP_READ);
	assign advance_s1 = valid_s1 && (!is_read_s1 || !out_valid_q || !out_stall);
	assign in_stall   = valid_s1 && !advance_s1;
	assign in_xfer    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			opcode_s1      <= opcode;
			latch_level_s1 <= latch_level;
			pad_buttons_s1 <= pad_buttons;
			move_dx_s1     <= $unsigned(move_dx);
			move_dy_s1     <= $unsigned(move_dy);
			button_bits_s1 <= button_bits;
			aim_x_s1       <= aim_x;
			aim_y_s1       <= aim_y;
		end
	end

	// device state update
	assign is_mouse    = (device_kind_q == KIND_MOUSE);
	assign mouse_build = build_mouse(mouse_speed_q, mouse_buttons_q, accum_x_q, accum_y_q);
	assign capture     = (device_kind_q == KIND_GUN) ?
		build_gun(gun_buttons_q, gun_offscreen_q) : pad_word_q;
	assign pad_shift   = latch_held_q ? capture : shift_word_q;

	always_comb begin
		latch_held_d    = latch_held_q;
		pad_word_d      = pad_word_q;
		shift_word_d    = shift_word_q;
		accum_x_d       = accum_x_q;
		accum_y_d       = accum_y_q;
		mouse_buttons_d = mouse_buttons_q;
		mouse_packet_d  = mouse_packet_q;
		mouse_count_d   = mouse_count_q;
		gun_buttons_d   = gun_buttons_q;
		gun_offscreen_d = gun_offscreen_q;
		bit_d           = 1'b1;
		case (opcode_s1)
			OP_LATCH: begin
				latch_held_d = latch_level_s1;
				if (latch_level_s1) begin
					if (is_mouse) begin
						mouse_packet_d = mouse_build;
						accum_x_d      = '0;
						accum_y_d      = '0;
						mouse_count_d  = '0;
					end else begin
						shift_word_d = capture;
					end
				end
			end
			OP_READ: begin
				if (is_mouse) begin
					if (latch_held_q) begin
						// re-latch without clearing the accumulators
						mouse_packet_d = mouse_build;
						mouse_count_d  = '0;
						bit_d          = mouse_build[31];
					end else if (mouse_count_q < MOUSE_BITS) begin
						bit_d         = mouse_packet_q[5'd31 - mouse_count_q[4:0]];
						mouse_count_d = mouse_count_q + 6'd1;
					end
				end else begin
					bit_d        = pad_shift[0];
					shift_word_d = (pad_shift >> 1) | PAD_FILL;
				end
			end
			OP_PAD: begin
				pad_word_d = pad_buttons_s1;
			end
			OP_MOUSE: begin
				accum_x_d       = accum_x_q + move_dx_s1;
				accum_y_d       = accum_y_q + move_dy_s1;
				mouse_buttons_d = button_bits_s1[1:0];
			end
			OP_GUN: begin
				gun_buttons_d   = button_bits_s1;
				gun_offscreen_d = (aim_x_s1[15:8] != 8'd0) || (aim_y_s1 >= GUN_Y_LIMIT);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_held_q    <= 1'b0;
			pad_word_q      <= '0;
			shift_word_q    <= '0;
			accum_x_q       <= '0;
			accum_y_q       <= '0;
			mouse_buttons_q <= '0;
			mouse_packet_q  <= '0;
			mouse_count_q   <= '0;
			gun_buttons_q   <= '0;
			gun_offscreen_q <= 1'b1;
		end else if (advance_s1) begin
			latch_held_q    <= latch_held_d;
			pad_word_q      <= pad_word_d;
			shift_word_q    <= shift_word_d;
			accum_x_q       <= accum_x_d;
			accum_y_q       <= accum_y_d;
			mouse_buttons_q <= mouse_buttons_d;
			mouse_packet_q  <= mouse_packet_d;
			mouse_count_q   <= mouse_count_d;
			gun_buttons_q   <= gun_buttons_d;
			gun_offscreen_q <= gun_offscreen_d;
		end
	end

	// output register: load a read result, drop after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && is_read_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && is_read_s1) begin
			data_bit_q <= bit_d;
		end
	end

	assign out_valid = out_valid_q;
	assign data_bit  = data_bit_q;

endmodule

// ----- hdl/sgp_checker.sv -----
`timescale 1ns / 1ps
module sgp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [2:0] opcode,
	input logic       out_valid,
	input logic       out_stall,
	input logic       data_bit
);
	import sgp_pkg::*;

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(data_bit))
		else $error("stalled result changed or dropped");

	// input backpressure only comes from a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	// a fresh result comes from an earlier read transfer at the input
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall && opcode == OP_READ, 2))
		else $error("result without a matching read");

endmodule

bind serial_game_port_shifter sgp_checker u_sgp_checker (.*);
